FILE: rtl/core/cesd_pkg.sv
// shared types, codes and character helpers of the escape sequence decoder
`default_nettype none

package cesd_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_EIGHT     = 8'h38;
  localparam logic [7:0] CH_NINE      = 8'h39;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_ESC     = 3'd1,
    MODE_HEX0    = 3'd2,
    MODE_HEX1    = 3'd3,
    MODE_OCT1    = 3'd4,
    MODE_OCT2    = 3'd5,
    MODE_DISCARD = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_NO_END  = 3'd1,
    ERR_HEX     = 3'd2,
    ERR_OCT     = 3'd3,
    ERR_OVER    = 3'd4,
    ERR_UNKNOWN = 3'd5
  } err_t;

  typedef struct packed {
    logic [7:0] out_byte;
    err_t       error_code;
    logic       eos;
  } res_t;

  // one queue entry: one or two results caused by one input beat
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  typedef struct packed {
    mode_t mode;
  } front_stat_t;

  // {valid, value}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic [8:0] named_val(input logic [7:0] c);
    logic [8:0] r;
    r = 9'd0;
    case (c)
      8'h61: r = {1'b1, 8'd7};
      8'h62: r = {1'b1, 8'd8};
      8'h66: r = {1'b1, 8'd12};
      8'h6E: r = {1'b1, 8'd10};
      8'h72: r = {1'b1, 8'd13};
      8'h74: r = {1'b1, 8'd9};
      8'h76: r = {1'b1, 8'd11};
      8'h5C, 8'h3F, 8'h27, 8'h22: r = {1'b1, c};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cesd_front.sv
// front part: escape state machine, turns the input bytes into queue entries
`default_nettype none

module cesd_front
  import cesd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        take,
  input  wire logic [7:0]  c,
  input  wire logic        last,
  output logic             push,
  output entry_t           entry,
  output front_stat_t      stat
);

  mode_t      mode_r, mode_nxt;
  logic [5:0] part_r, part_nxt;

  logic [4:0] hx;
  logic [8:0] nm;
  logic       is_oct, is_89, is_bs;
  logic [2:0] od;
  logic [5:0] oct1_val;
  logic [8:0] oct2_val;
  mode_t      fail_mode;
  mode_t      fresh_mode;
  res_t       fresh_res;
  logic       fresh_has;

  always_comb begin
    hx         = hex_nibble(c);
    nm         = named_val(c);
    is_oct     = (c[7:3] == 5'b00110);
    is_89      = (c == CH_EIGHT) || (c == CH_NINE);
    is_bs      = (c == CH_BACKSLASH);
    od         = c[2:0];
    oct1_val   = {part_r[2:0], od};
    oct2_val   = {part_r, od};
    fail_mode  = last ? MODE_IDLE : MODE_DISCARD;
    fresh_mode = (is_bs && !last) ? MODE_ESC : MODE_IDLE;
    fresh_has  = !(is_bs && !last);
    if (is_bs) fresh_res = '{8'd0, ERR_NO_END, 1'b1};
    else       fresh_res = '{c, ERR_NONE, last};
  end

  // next state
  always_comb begin
    mode_nxt = mode_r;
    part_nxt = part_r;
    unique case (mode_r)
      MODE_IDLE: begin
        mode_nxt = fresh_mode;
        part_nxt = '0;
      end
      MODE_ESC: begin
        part_nxt = '0;
        if (c == CH_X) begin
          mode_nxt = last ? MODE_IDLE : MODE_HEX0;
        end else if (is_oct) begin
          mode_nxt = last ? MODE_IDLE : MODE_OCT1;
          part_nxt = last ? 6'd0 : {3'd0, od};
        end else if (is_89) begin
          mode_nxt = fail_mode;
        end else if (nm[8]) begin
          mode_nxt = MODE_IDLE;
        end else begin
          mode_nxt = fail_mode;
        end
      end
      MODE_HEX0: begin
        part_nxt = '0;
        if (!hx[4]) begin
          mode_nxt = fail_mode;
        end else if (last) begin
          mode_nxt = MODE_IDLE;
        end else begin
          mode_nxt = MODE_HEX1;
          part_nxt = {2'd0, hx[3:0]};
        end
      end
      MODE_HEX1: begin
        part_nxt = '0;
        mode_nxt = hx[4] ? MODE_IDLE : fresh_mode;
      end
      MODE_OCT1: begin
        if (is_oct && !last) begin
          mode_nxt = MODE_OCT2;
          part_nxt = oct1_val;
        end else begin
          mode_nxt = is_oct ? MODE_IDLE : fresh_mode;
          part_nxt = '0;
        end
      end
      MODE_OCT2: begin
        part_nxt = '0;
        if (is_oct) mode_nxt = oct2_val[8] ? fail_mode : MODE_IDLE;
        else        mode_nxt = fresh_mode;
      end
      MODE_DISCARD: begin
        if (last) begin
          mode_nxt = MODE_IDLE;
          part_nxt = '0;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
        part_nxt = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    push  = 1'b0;
    entry = '{1'b0, '{8'd0, ERR_NONE, 1'b0}, fresh_res};
    unique case (mode_r)
      MODE_IDLE: begin
        push     = fresh_has;
        entry.r0 = fresh_res;
      end
      MODE_ESC: begin
        if (c == CH_X) begin
          push     = last;
          entry.r0 = '{8'd0, ERR_NO_END, 1'b1};
        end else if (is_oct) begin
          push     = last;
          entry.r0 = '{{5'd0, od}, ERR_NONE, last};
        end else if (is_89) begin
          push     = 1'b1;
          entry.r0 = '{8'd0, ERR_OCT, 1'b1};
        end else if (nm[8]) begin
          push     = 1'b1;
          entry.r0 = '{nm[7:0], ERR_NONE, last};
        end else begin
          push     = 1'b1;
          entry.r0 = '{8'd0, ERR_UNKNOWN, 1'b1};
        end
      end
      MODE_HEX0: begin
        if (!hx[4]) begin
          push     = 1'b1;
          entry.r0 = '{8'd0, ERR_HEX, 1'b1};
        end else begin
          push     = last;
          entry.r0 = '{{4'd0, hx[3:0]}, ERR_NONE, last};
        end
      end
      MODE_HEX1: begin
        push = 1'b1;
        if (hx[4]) begin
          entry.r0 = '{{part_r[3:0], hx[3:0]}, ERR_NONE, last};
        end else begin
          entry.r0  = '{{2'd0, part_r}, ERR_NONE, 1'b0};
          entry.two = fresh_has;
        end
      end
      MODE_OCT1: begin
        if (is_oct) begin
          push     = last;
          entry.r0 = '{{2'd0, oct1_val}, ERR_NONE, last};
        end else begin
          push      = 1'b1;
          entry.r0  = '{{2'd0, part_r}, ERR_NONE, 1'b0};
          entry.two = fresh_has;
        end
      end
      MODE_OCT2: begin
        push = 1'b1;
        if (is_oct) begin
          if (oct2_val[8]) entry.r0 = '{8'd0, ERR_OVER, 1'b1};
          else             entry.r0 = '{oct2_val[7:0], ERR_NONE, last};
        end else begin
          entry.r0  = '{{2'd0, part_r}, ERR_NONE, 1'b0};
          entry.two = fresh_has;
        end
      end
      MODE_DISCARD: push = 1'b0;
      default:      push = 1'b0;
    endcase
    push = push && take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      part_r <= '0;
    end else if (take) begin
      mode_r <= mode_nxt;
      part_r <= part_nxt;
    end
  end

  assign stat.mode = mode_r;

endmodule

`default_nettype wire

FILE: rtl/core/cesd_queue.sv
// short entry queue between the front and back parts
`default_nettype none

module cesd_queue
  import cesd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_data,
  output logic        full,
  input  wire logic   pop,
  output logic        empty,
  output entry_t      head
);

  entry_t         mem_r [QDEPTH];
  logic [QAW-1:0] wr_r, rd_r;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop)  rd_r <= rd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_data;
  end

endmodule

`default_nettype wire

FILE: rtl/core/cesd_back.sv
// back part: hands out the one or two results of each queued entry
`default_nettype none

module cesd_back
  import cesd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_empty,
  input  wire entry_t head,
  output logic        q_pop,
  input  wire logic   pop,
  output logic        empty,
  output res_t        res
);

  logic sub_r, sub_nxt;
  logic take;

  assign empty = q_empty;
  assign res   = sub_r ? head.r1 : head.r0;
  assign take  = pop && !q_empty;
  // second beat still owed: keep the entry
  assign q_pop = take && !(head.two && !sub_r);

  always_comb begin
    sub_nxt = sub_r;
    if (take) sub_nxt = head.two && !sub_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sub_r <= 1'b0;
    else        sub_r <= sub_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/core/c_escape_sequence_decoder.sv
// top level of the c string escape sequence decoder
// a result is written into the entry queue and read from its head onto the out_ ports
// throughput: one input beat per cycle while in_full is low; an escape ended by a foreign byte gives
//   two results, which leave on two separate pops while the 4-entry queue absorbs input
// in_full rises when the entry queue holds 4 entries
// reset (rst_n low, synchronous): no escape pending, queue empty, out_empty high
`default_nettype none

module c_escape_sequence_decoder
  import cesd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_char_in,
  input  wire logic       in_last_of_string,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [7:0]      out_byte,
  output logic [2:0]      out_error_code,
  output logic            out_end_of_string
);

  // handshake between the parts
  logic        take;
  logic        q_push;
  entry_t      q_data;
  logic        q_full;
  logic        q_pop;
  logic        q_empty;
  entry_t      q_head;
  front_stat_t fstat;
  res_t        res;

  // a beat is taken only when its entry is sure to fit
  assign in_full = q_full;
  assign take    = in_push && !q_full;

  // front: escape state machine
  cesd_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .c     (in_char_in),
    .last  (in_last_of_string),
    .push  (q_push),
    .entry (q_data),
    .stat  (fstat)
  );

  // entries decouple the decoder from output stalls
  cesd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // back: splits two-result entries into separate beats
  cesd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .head    (q_head),
    .q_pop   (q_pop),
    .pop     (out_pop),
    .empty   (out_empty),
    .res     (res)
  );

  assign out_byte          = res.out_byte;
  assign out_error_code    = res.error_code;
  assign out_end_of_string = res.eos;

  // discarding after an error never produces results
  a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (fstat.mode == MODE_DISCARD) |-> !q_push)
    else $error("result produced while discarding");

  // an error in the first result of an entry is always a lone, final result
  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_data.r0.error_code != ERR_NONE) |-> (q_data.r0.eos && !q_data.two))
    else $error("error entry not final");

  a_error_eos: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_error_code != ERR_NONE) |-> out_end_of_string)
    else $error("error result without end of string");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("queue not empty after reset");

endmodule

`default_nettype wire

FILE: verif/c_escape_sequence_decoder_tb.sv
// self-checking testbench of the c string escape sequence decoder
`default_nettype none

module c_escape_sequence_decoder_tb
  import cesd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // run shape
  localparam int TOTAL_BEATS  = 1575;  // directed beats plus about 1550 random ones
  localparam int HOLD_AT      = 400;   // receiver holds off once this many beats went in
  localparam int DRAIN_AT     = 800;   // sender waits for an empty scoreboard here
  localparam int CALM_AT      = 1350;  // no idling on either side from here on
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 10;
  localparam int STALL_LIMIT  = 4000;  // cycles with no beat on either side

  // characters that may follow a backslash as a named escape
  localparam logic [7:0] NAMED_CHARS [11] = '{
    8'h61, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74, 8'h76, 8'h5C, 8'h3F, 8'h27, 8'h22
  };

  // predicts the decoded bytes of the byte stream and checks them in order
  class escape_scoreboard;
    typedef struct packed {
      logic [7:0] val;
      err_t       err;
      logic       eos;
    } decoded_t;

    decoded_t   decoded_q[$];
    mode_t      mode;
    logic [8:0] digits;
    int         errors;

    function new();
      mode   = MODE_IDLE;
      digits = '0;
      errors = 0;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    function void emit(logic [7:0] val, err_t err, logic eos);
      decoded_t d;
      d.val = val;
      d.err = err;
      d.eos = eos;
      decoded_q.push_back(d);
    endfunction

    // an error closes the string; the rest of it is thrown away
    function void raise(err_t err, logic last);
      emit(8'h00, err, 1'b1);
      mode   = last ? MODE_IDLE : MODE_DISCARD;
      digits = '0;
    endfunction

    function void settle(logic [7:0] val, logic last);
      mode   = MODE_IDLE;
      digits = '0;
      emit(val, ERR_NONE, last);
    endfunction

    function void take_fresh(logic [7:0] c, logic last);
      mode   = MODE_IDLE;
      digits = '0;
      if (c != CH_BACKSLASH) emit(c, ERR_NONE, last);
      else if (last) raise(ERR_NO_END, last);
      else mode = MODE_ESC;
    endfunction

    function bit hex_of(input logic [7:0] c, output logic [3:0] v);
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
      else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h61 + 8'd10);
      else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h41 + 8'd10);
      else return 1'b0;
      return 1'b1;
    endfunction

    function bit is_octal(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h37;
    endfunction

    function bit named_of(input logic [7:0] c, output logic [7:0] v);
      v = c;
      case (c)
        8'h61: v = 8'd7;
        8'h62: v = 8'd8;
        8'h66: v = 8'd12;
        8'h6E: v = 8'd10;
        8'h72: v = 8'd13;
        8'h74: v = 8'd9;
        8'h76: v = 8'd11;
        8'h5C, 8'h3F, 8'h27, 8'h22: v = c;
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function void note_beat(logic [7:0] c, logic last);
      logic [3:0] h;
      logic [7:0] nv;
      logic [8:0] ov;
      case (mode)
        MODE_ESC: begin
          if (c == CH_X) begin
            if (last) raise(ERR_NO_END, last);
            else mode = MODE_HEX0;
          end else if (is_octal(c)) begin
            if (last) settle({5'd0, c[2:0]}, last);
            else begin
              digits = {6'd0, c[2:0]};
              mode   = MODE_OCT1;
            end
          end else if (c == CH_EIGHT || c == CH_NINE) begin
            raise(ERR_OCT, last);
          end else if (named_of(c, nv)) begin
            settle(nv, last);
          end else begin
            raise(ERR_UNKNOWN, last);
          end
        end
        MODE_HEX0: begin
          if (!hex_of(c, h)) raise(ERR_HEX, last);
          else if (last) settle({4'd0, h}, last);
          else begin
            digits = {5'd0, h};
            mode   = MODE_HEX1;
          end
        end
        MODE_HEX1: begin
          if (hex_of(c, h)) settle({digits[3:0], h}, last);
          else begin
            emit(digits[7:0], ERR_NONE, 1'b0);
            take_fresh(c, last);
          end
        end
        MODE_OCT1: begin
          if (is_octal(c)) begin
            digits = {3'd0, digits[2:0], c[2:0]};
            if (last) settle(digits[7:0], last);
            else mode = MODE_OCT2;
          end else begin
            emit(digits[7:0], ERR_NONE, 1'b0);
            take_fresh(c, last);
          end
        end
        MODE_OCT2: begin
          if (is_octal(c)) begin
            ov = {digits[5:0], c[2:0]};
            if (ov[8]) raise(ERR_OVER, last);
            else settle(ov[7:0], last);
          end else begin
            emit(digits[7:0], ERR_NONE, 1'b0);
            take_fresh(c, last);
          end
        end
        MODE_DISCARD: begin
          if (last) begin
            mode   = MODE_IDLE;
            digits = '0;
          end
        end
        default: take_fresh(c, last);
      endcase
    endfunction

    function void check_result(logic [7:0] val, logic [2:0] err, logic eos);
      decoded_t want;
      if (decoded_q.size() == 0) begin
        errors++;
        $display("%0t: expected no result, actual byte %h error %0d eos %b",
                 $time, val, err, eos);
        return;
      end
      want = decoded_q.pop_front();
      if (want.val !== val || want.err !== err || want.eos !== eos) begin
        errors++;
        $display("%0t: expected byte %h error %0d eos %b, actual byte %h error %0d eos %b",
                 $time, want.val, want.err, want.eos, val, err, eos);
      end
    endfunction
  endclass

  logic       clk               = 1'b0;
  logic       rst_n             = 1'b0;
  logic       in_push           = 1'b0;
  logic [7:0] in_char_in        = 8'h00;
  logic       in_last_of_string = 1'b0;
  logic       out_pop           = 1'b0;
  logic       in_full;
  logic       out_empty;
  logic [7:0] out_byte;
  logic [2:0] out_error_code;
  logic       out_end_of_string;

  escape_scoreboard sb = new();

  logic [7:0] text_q[$];  // bytes of the string being sent
  int         beats_sent  = 0;
  int         idle_cycles = 0;
  bit         calm        = 1'b0;  // final stretch, no idling
  bit         hold_req    = 1'b0;  // asks the receiver for its long hold-off
  bit         hold_done   = 1'b0;
  bit         drained     = 1'b0;

  c_escape_sequence_decoder DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_char_in        (in_char_in),
    .in_last_of_string (in_last_of_string),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_byte          (out_byte),
    .out_error_code    (out_error_code),
    .out_end_of_string (out_end_of_string)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // both channels are watched at the edge where a beat is taken; all driving is
  // nonblocking, so the values seen here are the ones the block sees
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (in_push && !in_full) sb.note_beat(in_char_in, in_last_of_string);
      if (out_pop && !out_empty)
        sb.check_result(out_byte, out_error_code, out_end_of_string);
      if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog: the run is stuck if nothing moves for too long
  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: pops with random bursts of idling, plus one long hold-off so the
  // entry queue fills and in_full pushes back on the sender
  initial begin
    wait (rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // offer one beat, maybe after a short gap, and hold it until it is taken
  task automatic send_beat(input logic [7:0] c, input logic last);
    if (!calm && $urandom_range(0, 11) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_push           <= 1'b1;
    in_char_in        <= c;
    in_last_of_string <= last;
    do @(posedge clk); while (in_full);
    beats_sent++;
  endtask

  // send text_q as one string, last flag on its final byte
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_beat(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] base;
    if (v < 4'd10) return 8'h30 + 8'(v);
    base = $urandom_range(0, 1) ? 8'h41 : 8'h61;  // either case
    return base + 8'(v) - 8'd10;
  endfunction

  // append one token of source text: mostly well-formed, some broken escapes
  function automatic void add_token();
    int         kind;
    int         n;
    int         d;
    logic [7:0] c;
    kind = $urandom_range(0, 19);
    if (kind <= 5) begin
      c = 8'($urandom_range(0, 255));
      if (c == CH_BACKSLASH) c = 8'h5B;
      text_q.push_back(c);
    end else if (kind <= 8) begin
      text_q.push_back(CH_BACKSLASH);
      text_q.push_back(NAMED_CHARS[$urandom_range(0, 10)]);
    end else if (kind <= 11) begin
      text_q.push_back(CH_BACKSLASH);
      text_q.push_back(CH_X);
      n = $urandom_range(1, 2);
      repeat (n) text_q.push_back(hex_char(4'($urandom_range(0, 15))));
    end else if (kind <= 14) begin
      // octal escape; three digits mostly stay in range, sometimes overflow
      text_q.push_back(CH_BACKSLASH);
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        if (i == 0 && n == 3 && $urandom_range(0, 3) != 0) d = $urandom_range(0, 3);
        else d = $urandom_range(0, 7);
        text_q.push_back(8'h30 + 8'(d));
      end
    end else if (kind == 15) begin
      text_q.push_back(CH_BACKSLASH);
      text_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind == 16) begin
      text_q.push_back(CH_BACKSLASH);
      text_q.push_back($urandom_range(0, 1) ? CH_EIGHT : CH_NINE);
    end else if (kind == 17) begin
      text_q.push_back(CH_BACKSLASH);
      text_q.push_back(CH_X);
      text_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind == 18) begin
      text_q.push_back(CH_BACKSLASH);
    end else begin
      text_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void build_string();
    int n;
    text_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      // noise: raw bytes, backslashes included
      n = $urandom_range(1, 6);
      repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) add_token();
    end
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    text_q = {8'h00, 8'hFF};                        send_text();  // byte extremes
    text_q = {CH_BACKSLASH};                        send_text();  // backslash at the end
    text_q = {CH_BACKSLASH, CH_X};                  send_text();  // \x at the end
    text_q = {CH_BACKSLASH, CH_EIGHT, 8'h7A};       send_text();  // \8, then discard
    text_q = {CH_BACKSLASH, CH_X, 8'h67};           send_text();  // bad hex digit
    text_q = {CH_BACKSLASH, 8'h34, 8'h30, 8'h30};   send_text();  // octal overflow
    text_q = {CH_BACKSLASH, 8'h71};                 send_text();  // unknown escape
    text_q = {CH_BACKSLASH, 8'h31, 8'h41};          send_text();  // octal cut by a letter
    text_q = {CH_BACKSLASH, CH_X, 8'h46, 8'h7A};    send_text();  // hex cut by a letter
    text_q = {CH_BACKSLASH, 8'h31, 8'h32};          send_text();  // octal cut by the end

    // random part
    while (beats_sent < TOTAL_BEATS) begin
      if (beats_sent >= HOLD_AT) hold_req = 1'b1;
      if (beats_sent >= CALM_AT) calm = 1'b1;
      if (!drained && beats_sent >= DRAIN_AT) begin
        // sender pause until every predicted byte has come out
        in_push <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        @(posedge clk);
        drained = 1'b1;
      end
      build_string();
      send_text();
    end
    in_push <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

FILE: c_escape_sequence_decoder.f
rtl/core/cesd_pkg.sv
rtl/core/cesd_front.sv
rtl/core/cesd_queue.sv
rtl/core/cesd_back.sv
rtl/core/c_escape_sequence_decoder.sv
verif/c_escape_sequence_decoder_tb.sv
